[hw/rtl/itt_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Integer-to-text shared definitions
// Character codes, accepted base codes and the digit shift type used by the
// power-of-two radix text converter.
// ----------------------------------------------------------------------------
package itt_pkg;

	// Digit shift per base: 1 for base 2 up to 5 for base 32, 0 for a bad base.
	typedef logic [2:0] shift_t;

	// ASCII characters of the text.
	typedef logic [6:0] char_t;

	localparam char_t CHAR_ZERO  = 7'h30;
	localparam char_t CHAR_UPPER = 7'h41;
	localparam char_t CHAR_MINUS = 7'h2D;
	localparam char_t CHAR_NONE  = 7'h00;

	// Accepted base codes.
	localparam logic [5:0] RADIX_2  = 6'd2;
	localparam logic [5:0] RADIX_4  = 6'd4;
	localparam logic [5:0] RADIX_8  = 6'd8;
	localparam logic [5:0] RADIX_16 = 6'd16;
	localparam logic [5:0] RADIX_32 = 6'd32;

	// Widest digit, in bits.
	localparam int DIGIT_MAX_BITS = 5;

	// Digits below this value are decimal characters.
	localparam logic [4:0] DEC_DIGITS = 5'd10;

	// Maps a base to its digit width; zero marks a base that is not accepted.
	function automatic shift_t radix_shift(input logic [5:0] radix);
		shift_t s;
		case (radix)
			RADIX_2:  s = 3'd1;
			RADIX_4:  s = 3'd2;
			RADIX_8:  s = 3'd3;
			RADIX_16: s = 3'd4;
			RADIX_32: s = 3'd5;
			default:  s = 3'd0;
		endcase
		return s;
	endfunction

	// ASCII character of one digit value.
	function automatic char_t digit_char(input logic [4:0] d);
		char_t c;
		if (d < DEC_DIGITS) begin
			c = CHAR_ZERO + {2'b00, d};
		end else begin
			c = CHAR_UPPER + {2'b00, d} - {2'b00, DEC_DIGITS};
		end
		return c;
	endfunction

endpackage

[hw/rtl/int_to_text_pow2_radix.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Integer to text, power-of-two radix
// Converts a signed integer to ASCII text in base 2, 4, 8, 16 or 32, one
// character per result, most significant character first.
// ----------------------------------------------------------------------------
// A request is taken when start is high and busy is low. A negative value
// gives its '-' on strobe in the cycle right after the request; digits then
// follow at one per cycle from the leading nonzero digit on, the last one
// flagged by last_char. The digit sequencer walks every digit position of
// the value width, skipping leading zeros silently, so a request keeps busy
// high until the last position has been walked. A zero value or a bad base
// gives its single result in the cycle after the request and leaves busy
// low. The receiver cannot stall: each result is on the ports for exactly
// one cycle, marked by strobe.
module int_to_text_pow2_radix #(
	parameter int VALUE_BITS = 32
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	output logic                  busy,
	input  logic [VALUE_BITS-1:0] value,
	input  logic [5:0]            radix,
	output logic                  strobe,
	output logic [6:0]            text_char,
	output logic                  last_char,
	output logic                  bad_base
);

	import itt_pkg::*;

	// Digit counts for each digit width, and the top padding of the digit register.
	localparam int ND1 = VALUE_BITS;
	localparam int ND2 = (VALUE_BITS + 1) / 2;
	localparam int ND3 = (VALUE_BITS + 2) / 3;
	localparam int ND4 = (VALUE_BITS + 3) / 4;
	localparam int ND5 = (VALUE_BITS + 4) / 5;
	localparam int PAD_MAX = DIGIT_MAX_BITS - 1;
	localparam int SR_BITS = VALUE_BITS + PAD_MAX;
	localparam int CW = $clog2(VALUE_BITS);

	typedef enum logic [0:0] {
		ST_IDLE,
		ST_RUN
	} state_t;

	state_t                  state_q;
	shift_t                  shift_q;
	logic [SR_BITS-1:0]      sr_q;
	logic [CW-1:0]           cnt_q;
	logic                    started_q;

	shift_t                  in_shift;
	logic                    in_neg;
	logic [VALUE_BITS-1:0]   in_mag;
	logic [SR_BITS-1:0]      in_sr;
	logic [CW-1:0]           in_cnt;
	logic [2:0]              in_lsh;
	logic [DIGIT_MAX_BITS-1:0] top_bits;
	logic [DIGIT_MAX_BITS-1:0] digit;
	logic                    emit;
	logic                    accept;

	assign busy   = (state_q != ST_IDLE);
	assign accept = start && !busy;

	// Decode the request: digit width, sign and unsigned magnitude.
	assign in_shift = radix_shift(radix);
	assign in_neg   = value[VALUE_BITS-1];
	assign in_mag   = in_neg ? (~value + 1'b1) : value;

	// Digit count and left alignment so that the leading digit sits at the top.
	always_comb begin
		case (in_shift)
			3'd1: begin
				in_cnt = CW'(ND1 - 1);
				in_lsh = 3'(PAD_MAX - (ND1 * 1 - VALUE_BITS));
			end
			3'd2: begin
				in_cnt = CW'(ND2 - 1);
				in_lsh = 3'(PAD_MAX - (ND2 * 2 - VALUE_BITS));
			end
			3'd3: begin
				in_cnt = CW'(ND3 - 1);
				in_lsh = 3'(PAD_MAX - (ND3 * 3 - VALUE_BITS));
			end
			3'd4: begin
				in_cnt = CW'(ND4 - 1);
				in_lsh = 3'(PAD_MAX - (ND4 * 4 - VALUE_BITS));
			end
			3'd5: begin
				in_cnt = CW'(ND5 - 1);
				in_lsh = 3'(PAD_MAX - (ND5 * 5 - VALUE_BITS));
			end
			default: begin
				in_cnt = '0;
				in_lsh = '0;
			end
		endcase
	end

	assign in_sr = {{PAD_MAX{1'b0}}, in_mag} << in_lsh;

	// Current digit: the top shift_q bits of the digit register.
	assign top_bits = sr_q[SR_BITS-1 -: DIGIT_MAX_BITS];
	assign digit    = top_bits >> (3'(DIGIT_MAX_BITS) - shift_q);

	// A digit is emitted once the leading nonzero digit is reached.
	assign emit = started_q || (digit != '0) || (cnt_q == '0);

	// Sequencer state and registered result ports.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			shift_q   <= '0;
			sr_q      <= '0;
			cnt_q     <= '0;
			strobe    <= 1'b0;
			text_char <= CHAR_NONE;
			last_char <= 1'b0;
			bad_base  <= 1'b0;
			started_q <= 1'b0;
		end else begin
			strobe <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						shift_q   <= in_shift;
						sr_q      <= in_sr;
						cnt_q     <= in_cnt;
						started_q <= 1'b0;
						if (in_shift == '0) begin
							strobe    <= 1'b1;
							text_char <= CHAR_NONE;
							last_char <= 1'b1;
							bad_base  <= 1'b1;
						end else if (value == '0) begin
							strobe    <= 1'b1;
							text_char <= CHAR_ZERO;
							last_char <= 1'b1;
							bad_base  <= 1'b0;
						end else begin
							state_q <= ST_RUN;
							if (in_neg) begin
								strobe    <= 1'b1;
								text_char <= CHAR_MINUS;
								last_char <= 1'b0;
								bad_base  <= 1'b0;
							end
						end
					end
				end
				ST_RUN: begin
					sr_q  <= sr_q << shift_q;
					cnt_q <= cnt_q - 1'b1;
					if (emit) begin
						started_q <= 1'b1;
						strobe    <= 1'b1;
						text_char <= digit_char(digit);
						last_char <= (cnt_q == '0);
						bad_base  <= 1'b0;
					end
					if (cnt_q == '0) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// A bad base result is always a single, empty character.
	a_bad_single: assert property (@(posedge clk) disable iff (!arst_n)
		(strobe && bad_base) |-> (last_char && text_char == CHAR_NONE))
		else $error("bad base result is not a single empty character");

	// The last digit position ends the conversion with a flagged result.
	a_run_ends: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_RUN && cnt_q == '0) |=> (state_q == ST_IDLE && strobe && last_char))
		else $error("conversion did not end with a last character");

	// A request for a bad base never enters the digit loop.
	a_bad_no_run: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && in_shift == '0) |=> (state_q == ST_IDLE))
		else $error("bad base entered digit loop");

endmodule

[tb/testbench.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Power-of-two radix integer-to-text converter testbench
// Sends requests of a signed value and a base, predicts the text
// characters of each one in order, and compares every strobed character
// against the oldest prediction. A directed table covers bad bases, zero,
// the extremes and every accepted base. Random requests then follow with
// random gaps on the request side.
// ----------------------------------------------------------------------------
module testbench;

	import itt_pkg::*;

	localparam int W           = 32;
	localparam int QUIET_LIMIT = 2000;
	localparam int RANDOM_REQS = 106;
	localparam int DRAIN_WAIT  = 40;
	localparam int N_DIRECTED  = 24;

	// One character as it leaves the converter.
	typedef struct packed {
		char_t ch;
		logic  last;
		logic  bad;
	} text_out_t;

	// One row of the directed table; known holds a hand-typed single result.
	typedef struct packed {
		logic [W-1:0] value;
		logic [5:0]   radix;
		logic         typed;
		text_out_t    known;
	} vector_t;

	logic         clk;
	logic         arst_n;
	logic         start;
	logic         busy;
	logic [W-1:0] value;
	logic [5:0]   radix;
	logic         strobe;
	logic [6:0]   text_char;
	logic         last_char;
	logic         bad_base;

	text_out_t pending_chars[$];
	text_out_t head_char;
	vector_t   directed [0:N_DIRECTED-1];
	int        errors;
	int        quiet;
	bit        burst;

	int_to_text_pow2_radix #(
		.VALUE_BITS(W)
	) dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.value     (value),
		.radix     (radix),
		.strobe    (strobe),
		.text_char (text_char),
		.last_char (last_char),
		.bad_base  (bad_base)
	);

	// Free-running clock.
	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// Queues the characters that a request of v in base r should produce.
	task automatic predict_text(input logic [W-1:0] v, input logic [5:0] r);
		int         shift;
		int         n;
		logic       neg;
		logic [W-1:0] mag;
		logic [4:0] digs [0:W-1];
		logic [4:0] d;
		case (r)
			RADIX_2:  shift = 1;
			RADIX_4:  shift = 2;
			RADIX_8:  shift = 3;
			RADIX_16: shift = 4;
			RADIX_32: shift = 5;
			default:  shift = 0;
		endcase
		if (shift == 0) begin
			pending_chars.push_back('{CHAR_NONE, 1'b1, 1'b1});
			return;
		end
		if (v == '0) begin
			pending_chars.push_back('{CHAR_ZERO, 1'b1, 1'b0});
			return;
		end
		neg = v[W-1];
		// The most negative value wraps to itself and reads correctly as unsigned.
		mag = neg ? -v : v;
		n = 0;
		while (mag != '0) begin
			digs[n] = 5'(mag & ((W'(1) << shift) - W'(1)));
			n++;
			mag = mag >> shift;
		end
		if (neg) begin
			pending_chars.push_back('{CHAR_MINUS, 1'b0, 1'b0});
		end
		for (int i = n - 1; i >= 0; i--) begin
			d = digs[i];
			if (d < DEC_DIGITS) begin
				pending_chars.push_back('{char_t'(CHAR_ZERO + d), i == 0, 1'b0});
			end else begin
				pending_chars.push_back('{char_t'(CHAR_UPPER + d - DEC_DIGITS), i == 0, 1'b0});
			end
		end
	endtask

	// Holds one request until it is taken, then idles for a random gap.
	// Entered and left at a falling edge.
	task automatic send_request(input vector_t row);
		int gap;
		start <= 1'b1;
		value <= row.value;
		radix <= row.radix;
		// Busy only changes at a rising edge, so it is stable at the falling edge.
		while (busy) @(negedge clk);
		@(posedge clk);
		if (row.typed) begin
			pending_chars.push_back(row.known);
		end else begin
			predict_text(row.value, row.radix);
		end
		if ($urandom_range(0, 9) == 0) begin
			burst = !burst;
		end
		gap = burst ? 0 : $urandom_range(0, 8);
		@(negedge clk);
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(negedge clk);
		end
	endtask

	// Holds off new requests until every predicted character has come out.
	task automatic drain_pause();
		start <= 1'b0;
		while (pending_chars.size() != 0) @(negedge clk);
		@(negedge clk);
	endtask

	// Draws one random request, mostly with a valid base.
	function automatic vector_t random_request();
		vector_t row;
		row = '0;
		if ($urandom_range(0, 4) == 0) begin
			row.radix = 6'($urandom_range(0, 63));
		end else begin
			case ($urandom_range(0, 4))
				0:       row.radix = RADIX_2;
				1:       row.radix = RADIX_4;
				2:       row.radix = RADIX_8;
				3:       row.radix = RADIX_16;
				default: row.radix = RADIX_32;
			endcase
		end
		case ($urandom_range(0, 11))
			0:       row.value = '0;
			1:       row.value = {1'b1, {(W-1){1'b0}}};
			default: row.value = W'($urandom) >> $urandom_range(0, W - 1);
		endcase
		if ($urandom_range(0, 1) == 1) begin
			row.value = -row.value;
		end
		return row;
	endfunction

	// Result checker: every strobed character must match the oldest prediction.
	always @(posedge clk) begin
		if (arst_n && strobe) begin
			if (pending_chars.size() == 0) begin
				errors++;
				$display("%0t: unexpected character: expected none, got char %h last %b bad %b",
					$time, text_char, last_char, bad_base);
			end else begin
				head_char = pending_chars.pop_front();
				if (head_char !== {text_char, last_char, bad_base}) begin
					errors++;
					$display("%0t: mismatch: expected char %h last %b bad %b,",
						$time, head_char.ch, head_char.last, head_char.bad,
						" got char %h last %b bad %b",
						text_char, last_char, bad_base);
				end
			end
		end
	end

	// Watchdog: ends the run after too many cycles with neither a request
	// nor a character taken.
	always @(posedge clk) begin
		if ((start && !busy) || strobe) begin
			quiet <= 0;
		end else begin
			quiet <= quiet + 1;
		end
		if (quiet == QUIET_LIMIT) begin
			$display("[int_to_text_pow2_radix] ERROR");
			$finish;
		end
	end

	// Stimulus and end of run.
	initial begin
		arst_n = 1'b0;
		start  = 1'b0;
		value  = '0;
		radix  = '0;
		errors = 0;
		quiet  = 0;
		burst  = 1'b0;

		// Directed table: bad bases and zero have their single result typed in.
		directed = '{
			'{32'h0000_0000, RADIX_16, 1'b1, '{CHAR_ZERO, 1'b1, 1'b0}},
			'{32'h0000_0000, 6'd3,     1'b1, '{CHAR_NONE, 1'b1, 1'b1}},
			'{32'h0000_0005, 6'd0,     1'b1, '{CHAR_NONE, 1'b1, 1'b1}},
			'{32'h0000_0005, 6'd1,     1'b1, '{CHAR_NONE, 1'b1, 1'b1}},
			'{32'hFFFF_FFFF, 6'd63,    1'b1, '{CHAR_NONE, 1'b1, 1'b1}},
			'{32'h8000_0000, 6'd10,    1'b1, '{CHAR_NONE, 1'b1, 1'b1}},
			'{32'h7FFF_FFFF, 6'd33,    1'b1, '{CHAR_NONE, 1'b1, 1'b1}},
			'{32'h7FFF_FFFF, RADIX_2,  1'b0, '0},
			'{32'h8000_0000, RADIX_2,  1'b0, '0},
			'{32'h8000_0000, RADIX_4,  1'b0, '0},
			'{32'h8000_0000, RADIX_8,  1'b0, '0},
			'{32'h8000_0000, RADIX_16, 1'b0, '0},
			'{32'h8000_0000, RADIX_32, 1'b0, '0},
			'{32'h7FFF_FFFF, RADIX_4,  1'b0, '0},
			'{32'h7FFF_FFFF, RADIX_8,  1'b0, '0},
			'{32'h7FFF_FFFF, RADIX_16, 1'b0, '0},
			'{32'h7FFF_FFFF, RADIX_32, 1'b0, '0},
			'{32'hFFFF_FFFF, RADIX_16, 1'b0, '0},
			'{32'h0000_0001, RADIX_2,  1'b0, '0},
			'{32'hFEDC_BA98, RADIX_16, 1'b0, '0},
			'{32'h0123_4567, RADIX_16, 1'b0, '0},
			'{32'h0000_001F, RADIX_32, 1'b0, '0},
			'{32'h0000_000A, RADIX_32, 1'b0, '0},
			'{32'h0000_0009, RADIX_16, 1'b0, '0}
		};

		repeat (10) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		for (int i = 0; i < N_DIRECTED; i++) begin
			send_request(directed[i]);
		end
		drain_pause();

		for (int i = 0; i < RANDOM_REQS; i++) begin
			if (i == RANDOM_REQS / 2) begin
				drain_pause();
			end
			send_request(random_request());
		end

		start <= 1'b0;
		while (pending_chars.size() != 0) @(posedge clk);
		repeat (DRAIN_WAIT) @(posedge clk);

		if (errors == 0) begin
			$display("[int_to_text_pow2_radix] OK");
		end else begin
			$display("[int_to_text_pow2_radix] ERROR");
		end
		$finish;
	end

endmodule

[filelist.f]
hw/rtl/itt_pkg.sv
hw/rtl/int_to_text_pow2_radix.sv
tb/testbench.sv
